>>> hdl/dsfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dust sensor frame parser package
// Shared constants, codes and the result record for the frame parser.
// ----------------------------------------------------------------------------
package dsfp_pkg;

  localparam int unsigned MAX_FRAME_LEN = 64;
  localparam int unsigned MIN_FRAME_LEN = 8;
  localparam int unsigned LEN_OFFSET    = 3;
  localparam int unsigned PREFIX_LEN    = 4;

  localparam logic [7:0]  PREFIX_FIRST  = 8'h42;
  localparam logic [7:0]  PREFIX_SECOND = 8'h4D;

  localparam int unsigned SUM_W    = 16;
  localparam int unsigned LEN_CFG_W = 7;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [LEN_CFG_W-1:0] LEN_TYPE_A_RST = 7'd32;
  localparam logic [LEN_CFG_W-1:0] LEN_TYPE_B_RST = 7'd24;

  typedef enum logic [1:0] {
    STAT_SUM_GOOD = 2'd0,
    STAT_SUM_BAD  = 2'd1,
    STAT_LEN_ERR  = 2'd2
  } frame_status_e;

  typedef enum logic [1:0] {
    TYPE_UNKNOWN = 2'd0,
    TYPE_A       = 2'd1,
    TYPE_B       = 2'd2
  } sensor_type_e;

  typedef enum logic {
    REG_LEN_TYPE_A = 1'b0,
    REG_LEN_TYPE_B = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    ST_HUNT   = 2'd0,
    ST_PREFIX = 2'd1,
    ST_FRAME  = 2'd2
  } parse_state_e;

  typedef struct packed {
    logic [1:0]           frame_status;
    logic [1:0]           sensor_type;
    logic [LEN_CFG_W-1:0] frame_length;
    logic [15:0]          first_word;
    logic [15:0]          second_word;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/dust_sensor_frame_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Dust sensor frame parser
// Parse particle sensor serial frames: prefix 0x42 0x4D, big-endian length,
// 16-bit byte sum checked against the trailing checksum, one result per frame.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       in_valid_i / in_stall_o  rx_byte_i
//   out       source     out_valid_o / out_stall_i frame_status_o, sensor_type_o,
//                                                frame_length_o, first_word_o,
//                                                second_word_o
//   cfg       APB slave  psel, penable, pready    paddr, pwdata, prdata
//
// Throughput is one byte per cycle while the output does not stall; a byte
// sits in the input register, then one pass of parser logic writes the
// result register as the frame's last byte leaves the input register.
// Reset clears the parser to prefix hunting and loads the type lengths.
// A stall on the output holds the input register only when it carries a
// byte and the result register is still full.
// ----------------------------------------------------------------------------
module dust_sensor_frame_parser_top #(
  parameter int unsigned MaxFrameLen = dsfp_pkg::MAX_FRAME_LEN
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Byte input
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      rx_byte_i,
  // Result output
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [1:0]                      frame_status_o,
  output logic      [1:0]                      sensor_type_o,
  output logic      [dsfp_pkg::LEN_CFG_W-1:0]  frame_length_o,
  output logic      [15:0]                     first_word_o,
  output logic      [15:0]                     second_word_o,
  // Configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dsfp_pkg::APB_AW-1:0]     paddr,
  input  wire logic [dsfp_pkg::APB_DW-1:0]     pwdata,
  output logic      [dsfp_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready
);
  import dsfp_pkg::*;

  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_byte_q;
  logic                 advance;
  logic                 in_take;
  logic [LEN_CFG_W-1:0] len_type_a, len_type_b;
  logic                 res_valid;
  result_t              res_comb, res_out;

  // Advance the held byte when the result register is empty or draining
  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  dsfp_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .len_type_a_o (len_type_a),
    .len_type_b_o (len_type_b)
  );

  dsfp_parser #(
    .MaxFrameLen (MaxFrameLen)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .len_type_a_i (len_type_a),
    .len_type_b_i (len_type_b),
    .res_valid_o  (res_valid),
    .res_o        (res_comb)
  );

  dsfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res_comb),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign frame_status_o = res_out.frame_status;
  assign sensor_type_o  = res_out.sensor_type;
  assign frame_length_o = res_out.frame_length;
  assign first_word_o   = res_out.first_word;
  assign second_word_o  = res_out.second_word;

`ifndef SYNTHESIS
  // A length error carries no length and no type
  a_len_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_status_o == STAT_LEN_ERR)) |->
      ((frame_length_o == '0) && (sensor_type_o == TYPE_UNKNOWN)))
    else $error("length error result carries nonzero fields");

  // A checked frame is never shorter than the minimum
  a_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_status_o != STAT_LEN_ERR)) |->
      (frame_length_o >= LEN_CFG_W'(MIN_FRAME_LEN)))
    else $error("checked frame shorter than minimum");

  // Input stall only while a byte waits in the input register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked byte");

  // Hold the input byte while the result register is blocked
  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_o && out_stall_i) |=>
      (in_valid_q && $stable(in_byte_q)))
    else $error("blocked input byte lost");
`endif

endmodule
`default_nettype wire

>>> hdl/dsfp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser configuration registers
// APB-style register file holding the two sensor type frame lengths.
// ----------------------------------------------------------------------------
module dsfp_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dsfp_pkg::APB_AW-1:0]     paddr,
  input  wire logic [dsfp_pkg::APB_DW-1:0]     pwdata,
  output logic      [dsfp_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready,
  output logic      [dsfp_pkg::LEN_CFG_W-1:0]  len_type_a_o,
  output logic      [dsfp_pkg::LEN_CFG_W-1:0]  len_type_b_o
);
  import dsfp_pkg::*;

  logic [LEN_CFG_W-1:0] len_a_q, len_a_d;
  logic [LEN_CFG_W-1:0] len_b_q, len_b_d;
  logic                 wr_en;
  reg_index_e           reg_idx;

  // Low address bits are ignored; bit 2 selects the register
  assign reg_idx = reg_index_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    len_a_d = len_a_q;
    len_b_d = len_b_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LEN_TYPE_A: len_a_d = pwdata[LEN_CFG_W-1:0];
        REG_LEN_TYPE_B: len_b_d = pwdata[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEN_TYPE_A: prdata = APB_DW'(len_a_q);
      REG_LEN_TYPE_B: prdata = APB_DW'(len_b_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= LEN_TYPE_A_RST;
      len_b_q <= LEN_TYPE_B_RST;
    end else begin
      len_a_q <= len_a_d;
      len_b_q <= len_b_d;
    end
  end

  assign len_type_a_o = len_a_q;
  assign len_type_b_o = len_b_q;

endmodule
`default_nettype wire

>>> hdl/dsfp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser core
// Prefix hunt, length check, running sum and result build, one byte a step.
// ----------------------------------------------------------------------------
module dsfp_parser #(
  parameter int unsigned MaxFrameLen = dsfp_pkg::MAX_FRAME_LEN
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic [7:0]                      byte_i,
  input  wire logic [dsfp_pkg::LEN_CFG_W-1:0]  len_type_a_i,
  input  wire logic [dsfp_pkg::LEN_CFG_W-1:0]  len_type_b_i,
  output logic                                 res_valid_o,
  output dsfp_pkg::result_t                    res_o
);
  import dsfp_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxFrameLen + 1);

  parse_state_e    state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_inc;
  logic [IdxW-1:0] exp_q, exp_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [7:0]      last_q, last_d;
  logic [7:0]      pay_q [4];
  logic [7:0]      pay_view [4];

  logic            is_len_hi, is_len_lo, len_err, frame_end, pay_wr;
  logic [8:0]      total;
  logic [SUM_W-1:0] calc_sum, given_sum;
  logic [7:0]      exp_ext;

  assign idx_inc   = idx_q + 1'b1;
  assign is_len_hi = (idx_q == IdxW'(LEN_OFFSET - 1));
  assign is_len_lo = (idx_q == IdxW'(LEN_OFFSET));
  assign total     = {1'b0, byte_i} + 9'(PREFIX_LEN);
  assign len_err   = (state_q == ST_FRAME) && is_len_lo &&
                     ((len_hi_q != 8'd0) || (total < 9'(MIN_FRAME_LEN)) ||
                      (total > 9'(MaxFrameLen)));
  assign frame_end = (state_q == ST_FRAME) && !is_len_hi && !is_len_lo &&
                     (idx_inc == exp_q);
  assign pay_wr    = (state_q == ST_FRAME) && (idx_q >= IdxW'(4)) &&
                     (idx_q <= IdxW'(7));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_HUNT:   if (byte_i == PREFIX_FIRST) state_d = ST_PREFIX;
      ST_PREFIX: state_d = (byte_i == PREFIX_SECOND) ? ST_FRAME : ST_HUNT;
      ST_FRAME:  if (len_err || frame_end) state_d = ST_HUNT;
      default:   state_d = ST_HUNT;
    endcase
  end

  // Frame counters and sum
  always_comb begin
    idx_d    = idx_q;
    exp_d    = exp_q;
    len_hi_d = len_hi_q;
    sum_d    = sum_q;
    last_d   = last_q;
    unique case (state_q)
      ST_PREFIX: begin
        if (byte_i == PREFIX_SECOND) begin
          idx_d = IdxW'(2);
          sum_d = SUM_W'(PREFIX_FIRST) + SUM_W'(PREFIX_SECOND);
        end
      end
      ST_FRAME: begin
        idx_d  = idx_inc;
        sum_d  = sum_q + SUM_W'(byte_i);
        last_d = byte_i;
        if (is_len_hi) begin
          len_hi_d = byte_i;
        end else if (is_len_lo) begin
          if (len_err) begin
            idx_d = '0;
            exp_d = IdxW'(MaxFrameLen);
          end else begin
            exp_d = IdxW'(total);
          end
        end else if (frame_end) begin
          idx_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Payload bytes as they stand after this byte
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pay_view[k] = (pay_wr && (idx_q[1:0] == 2'(k))) ? byte_i : pay_q[k];
    end
  end

  // Sum of all bytes but the trailing checksum pair
  assign calc_sum  = sum_q - SUM_W'(last_q);
  assign given_sum = {last_q, byte_i};
  assign exp_ext   = 8'(exp_q);

  // Result
  always_comb begin
    res_valid_o = len_err || frame_end;
    res_o       = '0;
    if (len_err) begin
      res_o.frame_status = STAT_LEN_ERR;
    end else begin
      res_o.frame_status = (calc_sum == given_sum) ? STAT_SUM_GOOD : STAT_SUM_BAD;
      if (exp_ext == {1'b0, len_type_a_i}) begin
        res_o.sensor_type = TYPE_A;
      end else if (exp_ext == {1'b0, len_type_b_i}) begin
        res_o.sensor_type = TYPE_B;
      end else begin
        res_o.sensor_type = TYPE_UNKNOWN;
      end
      res_o.frame_length = LEN_CFG_W'(exp_q);
      res_o.first_word   = {pay_view[0], pay_view[1]};
      res_o.second_word  = {pay_view[2], pay_view[3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      idx_q    <= '0;
      exp_q    <= IdxW'(MaxFrameLen);
      len_hi_q <= '0;
      sum_q    <= '0;
      last_q   <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      exp_q    <= exp_d;
      len_hi_q <= len_hi_d;
      sum_q    <= sum_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && pay_wr) begin
      pay_q[idx_q[1:0]] <= byte_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/dsfp_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame parser result register
// Hold one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dsfp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire dsfp_pkg::result_t res_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output dsfp_pkg::result_t      res_o
);
  import dsfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire
